// ===== rtl/byte_histogram_with_peak_macros.svh =====
// assertion macros for the histogram block
`ifndef BYTE_HISTOGRAM_WITH_PEAK_MACROS_SVH
`define BYTE_HISTOGRAM_WITH_PEAK_MACROS_SVH
`ifndef SYNTHESIS
// clocked property, off while reset is asserted
`define BHP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("histogram assertion failed");
// clocked property, checked during reset too
`define BHP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("histogram assertion failed");
`else
`define BHP_ASSERT(label, clk, rst_n, prop)
`define BHP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/bhp_pkg.sv =====
`default_nettype none
package bhp_pkg;

  localparam int unsigned SAMPLE_BITS  = 8;
  localparam int unsigned OUT_BITS     = 24;
  localparam int unsigned CFG_IDX_BITS = 1;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LOW  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_HIGH = 1'd1;

  localparam logic [SAMPLE_BITS-1:0] WINDOW_LOW_RST  = 8'd0;
  localparam logic [SAMPLE_BITS-1:0] WINDOW_HIGH_RST = 8'd255;

endpackage
`default_nettype wire

// ===== rtl/byte_histogram_with_peak.sv =====
// Byte histogram with interior peak tracking.
// Command channel: start_i with cmd_i, sample_i and bin_index_i is taken at a
// rising edge where start_i is high and busy_o is low. busy_o never rises, so
// one command beat is taken every cycle.
// Commands: add a sample to bin (sample - window_low), read a bin, clear all
// bins and the peak. Out-of-window samples and indexes set out_of_window_o and
// count nothing. Counts saturate at 2^COUNT_BITS - 1.
// Result: exactly one beat per command, registered after the s1 stage,
// shown for one cycle with done_o high; the receiver cannot stall it.
// Throughput is one command per cycle; the result passes through the
// registered read of the bin memory and the update stage that writes it back.
// Back-to-back hits on the same bin are forwarded from the last write.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 window_low,
// 1 window_high) and cfg_data_i; ready only while no command is in flight
// and none is offered on start_i.
// Reset: asynchronous, active low. Every bin has a valid flag in flops that
// reset and clear drop at once, so bins read as zero right away with no
// clearing sweep; windows go to 0 and 255.
`default_nettype none
`include "byte_histogram_with_peak_macros.svh"
module byte_histogram_with_peak
  import bhp_pkg::*;
#(
  parameter int unsigned NUM_BINS   = 256,
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic [1:0]              cmd_i,
  input  wire logic [SAMPLE_BITS-1:0]  sample_i,
  input  wire logic [SAMPLE_BITS-1:0]  bin_index_i,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [SAMPLE_BITS-1:0]  cfg_data_i,
  output logic                         done_o,
  output logic [OUT_BITS-1:0]          bin_count_o,
  output logic [OUT_BITS-1:0]          interior_peak_o,
  output logic                         out_of_window_o
);

  localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned WB = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

  logic [SAMPLE_BITS-1:0] win_low_q, win_high_q;

  logic [COUNT_BITS-1:0] mem_q [NUM_BINS];
  logic [COUNT_BITS-1:0] rdata_q;
  logic [NUM_BINS-1:0]   vld_q, vld_d;

  logic                   accept;
  logic [AW-1:0]          rd_addr;
  logic [SAMPLE_BITS-1:0] in_diff;

  logic                   s1_valid_q;
  cmd_e                   s1_cmd_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q, s1_idx_q;
  logic [AW-1:0]          s1_addr_q;

  logic                  fwd_valid_q, fwd_valid_d;
  logic [AW-1:0]         fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;

  logic [COUNT_BITS-1:0] peak_q, peak_d;

  logic                  done_q, done_d;
  logic [OUT_BITS-1:0]   res_cnt_q, res_cnt_d;
  logic                  res_oow_q, res_oow_d;

  logic [SAMPLE_BITS:0]   span, usable;
  logic [SAMPLE_BITS-1:0] s1_bin;
  logic                   add_ok, rd_ok;
  logic [COUNT_BITS-1:0]  old_cnt, new_cnt;
  logic                   wr_en;
  logic [WB-1:0]          cnt_ext, peak_ext;

  assign busy_o      = 1'b0;
  assign accept      = start_i && !busy_o;
  // a command taken at the same edge would see two different windows
  assign cfg_ready_o = !s1_valid_q && !start_i;

  // bin address for the memory read, issued on the command beat
  assign in_diff = sample_i - win_low_q;
  assign rd_addr = (cmd_e'(cmd_i) == CMD_READ) ? bin_index_i[AW-1:0] : in_diff[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_low_q  <= WINDOW_LOW_RST;
      win_high_q <= WINDOW_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WINDOW_LOW:  win_low_q  <= cfg_data_i;
        REG_WINDOW_HIGH: win_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // bin memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s1_addr_q] <= new_cnt;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q    <= cmd_e'(cmd_i);
      s1_sample_q <= sample_i;
      s1_idx_q    <= bin_index_i;
      s1_addr_q   <= rd_addr;
    end
  end

  // number of usable bins in the window
  always_comb begin
    span = {1'b0, win_high_q} - {1'b0, win_low_q} + (SAMPLE_BITS+1)'(1);
    if (win_high_q < win_low_q) begin
      usable = '0;
    end else if (span > (SAMPLE_BITS+1)'(NUM_BINS)) begin
      usable = (SAMPLE_BITS+1)'(NUM_BINS);
    end else begin
      usable = span;
    end
  end

  assign s1_bin = s1_sample_q - win_low_q;
  assign add_ok = (usable != '0) && (s1_sample_q >= win_low_q) && ({1'b0, s1_bin} < usable);
  assign rd_ok  = {1'b0, s1_idx_q} < usable;

  // last write lands at the same edge as this read, so take it from the bypass
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_addr_q)) begin
      old_cnt = fwd_data_q;
    end else if (vld_q[s1_addr_q]) begin
      old_cnt = rdata_q;
    end else begin
      old_cnt = '0;
    end
  end

  assign new_cnt = (old_cnt == '1) ? old_cnt : old_cnt + COUNT_BITS'(1);

  always_comb begin
    wr_en       = 1'b0;
    vld_d       = vld_q;
    peak_d      = peak_q;
    fwd_valid_d = 1'b0;
    done_d      = s1_valid_q;
    res_oow_d   = 1'b0;
    cnt_ext     = '0;
    if (s1_valid_q) begin
      case (s1_cmd_q)
        CMD_ADD: begin
          if (add_ok) begin
            wr_en              = 1'b1;
            fwd_valid_d        = 1'b1;
            vld_d[s1_addr_q]   = 1'b1;
            cnt_ext            = WB'(new_cnt);
            // interior bins only: not the first, not the last usable one
            if ((s1_bin != '0) && ({1'b0, s1_bin} + (SAMPLE_BITS+1)'(1) < usable)
                && (new_cnt > peak_q)) begin
              peak_d = new_cnt;
            end
          end else begin
            res_oow_d = 1'b1;
          end
        end
        CMD_READ: begin
          if (rd_ok) begin
            cnt_ext = WB'(old_cnt);
          end else begin
            res_oow_d = 1'b1;
          end
        end
        CMD_CLEAR: begin
          vld_d  = '0;
          peak_d = '0;
        end
        default: ;
      endcase
    end
    res_cnt_d = cnt_ext[OUT_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      peak_q      <= '0;
      fwd_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      vld_q       <= vld_d;
      peak_q      <= peak_d;
      fwd_valid_q <= fwd_valid_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= s1_addr_q;
    fwd_data_q <= new_cnt;
    res_cnt_q  <= res_cnt_d;
    res_oow_q  <= res_oow_d;
  end

  assign peak_ext        = WB'(peak_q);
  assign done_o          = done_q;
  assign bin_count_o     = res_cnt_q;
  assign interior_peak_o = peak_ext[OUT_BITS-1:0];
  assign out_of_window_o = res_oow_q;

  `BHP_ASSERT(a_result_follows, clk_i, rst_ni, (start_i && !busy_o) |-> ##2 done_o)
  `BHP_ASSERT(a_result_has_cmd, clk_i, rst_ni, done_o |-> $past(start_i && !busy_o, 2))
  `BHP_ASSERT(a_oow_zero, clk_i, rst_ni, (done_o && out_of_window_o) |-> (bin_count_o == '0))
  `BHP_ASSERT(a_peak_grows, clk_i, rst_ni,
    !(s1_valid_q && (s1_cmd_q == CMD_CLEAR)) |=> (peak_q >= $past(peak_q)))
  `BHP_ASSERT(a_fwd_valid_bin, clk_i, rst_ni, fwd_valid_q |-> vld_q[fwd_addr_q])

endmodule
`default_nettype wire
